// ----- rtl/msef_pkg.sv -----
// Package: shared types and constants of the median/spike/EMA weight filter.
`default_nettype none

package msef_pkg;

   // Payload and register widths
   localparam int SAMPLE_W      = 32;
   localparam int ELAPSED_W     = 16;
   localparam int INTERVAL_W    = 16;
   localparam int ALPHA_MAN_W   = 16;
   localparam int TAU_W         = 20;
   localparam int WINLEN_W      = 4;
   localparam int SPIKE_W       = 31;
   localparam int CSR_DATA_W    = 31;
   localparam int CSR_INDEX_W   = 3;

   // Register reset values
   localparam logic [INTERVAL_W-1:0]  INTERVAL_RESET  = 16'd120;
   localparam logic [ALPHA_MAN_W-1:0] ALPHA_MAN_RESET = 16'd13107;
   localparam logic [TAU_W-1:0]       TAU_RESET       = 20'd0;
   localparam logic [WINLEN_W-1:0]    WINLEN_RESET    = 4'd1;
   localparam logic [SPIKE_W-1:0]     SPIKE_RESET     = 31'd0;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SAMPLE_INTERVAL = 3'd0,
      CSR_ALPHA_MANUAL    = 3'd1,
      CSR_TIME_CONSTANT   = 3'd2,
      CSR_MEDIAN_WINDOW   = 3'd3,
      CSR_SPIKE_LIMIT     = 3'd4
   } csr_index_type;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_MED_LOAD,
      S_MED_CMP,
      S_SPK_DELTA,
      S_SPK_HI,
      S_SPK_LO,
      S_SPK_FIX,
      S_ALPHA,
      S_DIV_NUM,
      S_DIV_STEP,
      S_DIV_CLAMP,
      S_EMA_DIFF,
      S_EMA_MUL,
      S_EMA_RND,
      S_EMA_ADD,
      S_DONE
   } state_type;

   // Status of the shared adder
   typedef struct packed {
      logic neg;
      logic zero;
   } alu_flags_type;

   // Commands to the median window
   typedef struct packed {
      logic clear;
      logic push;
   } win_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/msef_if.sv -----
// Interfaces: sample request channel and filtered result channel.
`default_nettype none

interface msef_req_if;
   import msef_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [SAMPLE_W-1:0]  sample;
   logic [ELAPSED_W-1:0]        elapsed_ms;

   modport source (output valid, sample, elapsed_ms, input ready);
   modport sink   (input valid, sample, elapsed_ms, output ready);
endinterface

interface msef_rsp_if;
   import msef_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [SAMPLE_W-1:0]  filtered_weight;

   modport source (output valid, filtered_weight, input ready);
   modport sink   (input valid, filtered_weight, output ready);
endinterface

`default_nettype wire

// ----- rtl/msef_alu.sv -----
// Shared add/subtract unit used by the filter sequencer.
`default_nettype none

module msef_alu #(
   parameter int WIDTH = 36
) (
   input  wire logic [WIDTH-1:0]       a,
   input  wire logic [WIDTH-1:0]       b,
   input  wire logic                   sub,
   output logic [WIDTH-1:0]            sum,
   output msef_pkg::alu_flags_type     flags
);
   import msef_pkg::*;

   logic [WIDTH-1:0] b_op;

   // a + b or a - b with carry-in
   assign b_op       = sub ? ~b : b;
   assign sum        = a + b_op + WIDTH'(sub);
   assign flags.neg  = sum[WIDTH-1];
   assign flags.zero = (sum == '0);

endmodule

`default_nettype wire

// ----- rtl/msef_window.sv -----
// Median window: ring of recent samples with fill count and write pointer.
`default_nettype none

module msef_window #(
   parameter int MAX_WINDOW = 9
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire msef_pkg::win_ctrl_type              ctrl,
   input  wire logic [msef_pkg::WINLEN_W-1:0]       length,
   input  wire logic [msef_pkg::SAMPLE_W-1:0]       push_data,
   input  wire logic [$clog2(MAX_WINDOW)-1:0]       rd_addr,
   output logic [msef_pkg::SAMPLE_W-1:0]            rd_data,
   output logic [$clog2(MAX_WINDOW+1)-1:0]          fill
);
   import msef_pkg::*;

   localparam int IDX_W  = $clog2(MAX_WINDOW);
   localparam int FILL_W = $clog2(MAX_WINDOW + 1);

   logic [SAMPLE_W-1:0] store_ff [MAX_WINDOW];
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [IDX_W-1:0]    next_ff, next_in;
   logic [FILL_W-1:0]   len;
   logic [IDX_W-1:0]    wr_addr;
   logic [IDX_W-1:0]    ring_addr;
   logic                wr_en;

   assign len     = FILL_W'(length);
   assign rd_data = store_ff[rd_addr];
   assign fill    = fill_ff;

   // Pointer update: fill first, then overwrite the oldest entry
   always_comb begin
      fill_in   = fill_ff;
      next_in   = next_ff;
      wr_en     = 1'b0;
      ring_addr = (FILL_W'(next_ff) >= len) ? '0 : next_ff;
      wr_addr   = ring_addr;
      if (ctrl.clear) begin
         fill_in = '0;
         next_in = '0;
      end else if (ctrl.push) begin
         wr_en = 1'b1;
         if (fill_ff < len) begin
            wr_addr = fill_ff[IDX_W-1:0];
            fill_in = fill_ff + FILL_W'(1);
         end else begin
            next_in = (FILL_W'(ring_addr) + FILL_W'(1) == len) ? '0
                                                               : ring_addr + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         next_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         next_ff <= next_in;
      end
   end

   // Sample storage, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= push_data;
      end
   end

   a_clear_empties : assert property (@(posedge clock) disable iff (reset)
      ctrl.clear |=> fill_ff == '0)
      else $error("window not empty after clear");

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(MAX_WINDOW))
      else $error("window fill beyond depth");

endmodule

`default_nettype wire

// ----- rtl/median_spike_ema_filter.sv -----
// Top level: median window, spike clamp and EMA smoothing of weight samples.
//
// Usage: samples arrive on req_chan (valid/ready); each accepted transfer
// yields exactly one filtered_weight transfer on rsp_chan. Registers are
// written through csr_write_en/csr_index/csr_data while the filter is idle;
// writing median_window empties the window.
// Operation: one shared adder does the additions and subtractions under a
// sequencer, so an item takes several passes through it. After accept the
// median is found by rank counting (skipped when the window length is 1),
// then come the spike clamp, alpha select, the alpha division from the time
// constant, the EMA (difference, multiply, round, add) and the output load.
// req_chan.ready is high only while the sequencer is idle.
// Reset (synchronous) empties the window, forgets the last output and
// restores register defaults. A finished result sits in an output register;
// the next sample is taken while it waits, and a new result waits inside
// the sequencer until the receiver has taken the previous one.
`default_nettype none

module median_spike_ema_filter #(
   parameter int MAX_WINDOW      = 9,
   parameter int ALPHA_FRAC_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   msef_req_if.sink                               req_chan,
   msef_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_write_en,
   input  wire logic [msef_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [msef_pkg::CSR_DATA_W-1:0]   csr_data
);
   import msef_pkg::*;

   localparam int F         = ALPHA_FRAC_BITS;
   localparam int ALPHA_W   = F + 1;
   localparam int NUM_W     = F + 17;
   localparam int ALU_W     = (NUM_W > 36) ? NUM_W : 36;
   localparam int DEN_W     = 21;
   localparam int PROD_W    = F + 35;
   localparam int IDX_W     = $clog2(MAX_WINDOW);
   localparam int FILL_W    = $clog2(MAX_WINDOW + 1);
   localparam int CNT_W     = $clog2(F + 1);
   localparam int ALPHA_MIN_INT = ((1 << F) + 9999) / 10000;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = {1'b1, {F{1'b0}}};
   localparam logic [ALPHA_W-1:0] ALPHA_MIN = ALPHA_W'(ALPHA_MIN_INT);

   // Odd window length, limited to the window depth
   function automatic logic [WINLEN_W-1:0] odd_len(input logic [WINLEN_W-1:0] n);
      logic [WINLEN_W:0] m;
      m = {1'b0, n};
      if (m < (WINLEN_W+1)'(1)) m = (WINLEN_W+1)'(1);
      if (m > (WINLEN_W+1)'(MAX_WINDOW)) m = (WINLEN_W+1)'(MAX_WINDOW);
      if (!m[0]) m = m + (WINLEN_W+1)'(1);
      if (m > (WINLEN_W+1)'(MAX_WINDOW)) m = m - (WINLEN_W+1)'(2);
      return m[WINLEN_W-1:0];
   endfunction

   // Configuration registers
   logic [INTERVAL_W-1:0]  interval_ff;
   logic [ALPHA_MAN_W-1:0] alpha_man_ff;
   logic [TAU_W-1:0]       tau_ff;
   logic [WINLEN_W-1:0]    winlen_ff;
   logic [SPIKE_W-1:0]     spike_ff;

   // Sequencer registers
   state_type                  state_ff, state_in;
   logic [ELAPSED_W-1:0]       dt_ff, dt_in;
   logic [SAMPLE_W-1:0]        med_ff, med_in;
   logic [SAMPLE_W-1:0]        cand_ff, cand_in;
   logic [IDX_W-1:0]           i_ff, i_in;
   logic [IDX_W-1:0]           j_ff, j_in;
   logic [FILL_W-1:0]          rank_ff, rank_in;
   logic signed [ALU_W-1:0]    delta_ff, delta_in;
   logic                       lo_sel_ff, lo_sel_in;
   logic [ALPHA_W-1:0]         alpha_ff, alpha_in;
   logic [DEN_W-1:0]           den_ff, den_in;
   logic [DEN_W-1:0]           rem_ff, rem_in;
   logic [F:0]                 low_ff, low_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic [SAMPLE_W-1:0]        res_ff, res_in;
   logic [SAMPLE_W-1:0]        last_ff, last_in;
   logic                       seen_ff, seen_in;
   logic                       out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0]        out_data_ff, out_data_in;

   // Shared unit and window connections
   logic [ALU_W-1:0]    alu_a, alu_b, alu_sum;
   logic                alu_sub;
   alu_flags_type       alu_flags;
   win_ctrl_type        win_ctrl;
   logic [IDX_W-1:0]    win_rd_addr;
   logic [SAMPLE_W-1:0] win_rd_data;
   logic [FILL_W-1:0]   win_fill;

   // Helpers
   logic                     accept;
   logic [ELAPSED_W-1:0]     dt_raw;
   logic [ALU_W-1:0]         med_x, last_x, cand_x, rd_x, spike_x;
   logic [DEN_W:0]           div_trial;
   logic                     rank_inc;
   logic [FILL_W-1:0]        rank_next;
   logic signed [ALPHA_W:0]  alpha_s;
   logic signed [32:0]       diff_s;
   logic signed [PROD_W-1:0] prod_sh;
   logic signed [ALU_W-1:0]  step_half;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.filtered_weight = out_data_ff;

   assign med_x     = {{(ALU_W-SAMPLE_W){med_ff[SAMPLE_W-1]}}, med_ff};
   assign last_x    = {{(ALU_W-SAMPLE_W){last_ff[SAMPLE_W-1]}}, last_ff};
   assign cand_x    = {{(ALU_W-SAMPLE_W){cand_ff[SAMPLE_W-1]}}, cand_ff};
   assign rd_x      = {{(ALU_W-SAMPLE_W){win_rd_data[SAMPLE_W-1]}}, win_rd_data};
   assign spike_x   = ALU_W'(spike_ff);
   assign div_trial = {rem_ff, low_ff[F]};
   assign alpha_s   = {1'b0, alpha_ff};
   assign diff_s    = delta_ff[32:0];
   assign prod_sh   = prod_ff >>> (F - 1);
   assign step_half = delta_ff >>> 1;
   assign dt_raw    = seen_ff ? req_chan.elapsed_ms : interval_ff;
   assign rank_inc  = alu_flags.neg || (alu_flags.zero && (j_ff < i_ff));
   assign rank_next = rank_ff + FILL_W'(rank_inc);

   assign win_ctrl.clear = csr_write_en && (csr_index == CSR_MEDIAN_WINDOW);
   assign win_ctrl.push  = accept && (winlen_ff > WINLEN_W'(1));

   msef_alu #(.WIDTH(ALU_W)) u_alu (
      .a     (alu_a),
      .b     (alu_b),
      .sub   (alu_sub),
      .sum   (alu_sum),
      .flags (alu_flags)
   );

   msef_window #(.MAX_WINDOW(MAX_WINDOW)) u_window (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (win_ctrl),
      .length    (winlen_ff),
      .push_data (req_chan.sample),
      .rd_addr   (win_rd_addr),
      .rd_data   (win_rd_data),
      .fill      (win_fill)
   );

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= INTERVAL_RESET;
         alpha_man_ff <= ALPHA_MAN_RESET;
         tau_ff       <= TAU_RESET;
         winlen_ff    <= WINLEN_RESET;
         spike_ff     <= SPIKE_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SAMPLE_INTERVAL: interval_ff  <= csr_data[INTERVAL_W-1:0];
            CSR_ALPHA_MANUAL:    alpha_man_ff <= csr_data[ALPHA_MAN_W-1:0];
            CSR_TIME_CONSTANT:   tau_ff       <= csr_data[TAU_W-1:0];
            CSR_MEDIAN_WINDOW:   winlen_ff    <= odd_len(csr_data[WINLEN_W-1:0]);
            CSR_SPIKE_LIMIT:     spike_ff     <= csr_data[SPIKE_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: next state and datapath control
   always_comb begin
      state_in     = state_ff;
      dt_in        = dt_ff;
      med_in       = med_ff;
      cand_in      = cand_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      rank_in      = rank_ff;
      delta_in     = delta_ff;
      lo_sel_in    = lo_sel_ff;
      alpha_in     = alpha_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      low_in       = low_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      last_in      = last_ff;
      seen_in      = seen_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_data_in  = out_data_ff;
      alu_a        = '0;
      alu_b        = '0;
      alu_sub      = 1'b0;
      win_rd_addr  = i_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               dt_in = (dt_raw == '0) ? interval_ff : dt_raw;
               i_in  = '0;
               if (win_ctrl.push) begin
                  state_in = S_MED_LOAD;
               end else begin
                  med_in   = req_chan.sample;
                  state_in = S_SPK_DELTA;
               end
            end
         end

         // Latch the candidate whose rank is counted next
         S_MED_LOAD: begin
            win_rd_addr = i_ff;
            cand_in     = win_rd_data;
            j_in        = '0;
            rank_in     = '0;
            state_in    = S_MED_CMP;
         end

         // Rank count: entries below candidate, ties broken by position
         S_MED_CMP: begin
            win_rd_addr = j_ff;
            alu_a       = rd_x;
            alu_b       = cand_x;
            alu_sub     = 1'b1;
            if (FILL_W'(j_ff) == win_fill - FILL_W'(1)) begin
               if (rank_next == (win_fill >> 1)) begin
                  med_in   = cand_ff;
                  state_in = S_SPK_DELTA;
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  state_in = S_MED_LOAD;
               end
            end else begin
               j_in    = j_ff + IDX_W'(1);
               rank_in = rank_next;
            end
         end

         // Step from the last output
         S_SPK_DELTA: begin
            if (spike_ff == '0 || !seen_ff) begin
               state_in = S_ALPHA;
            end else begin
               alu_a    = med_x;
               alu_b    = last_x;
               alu_sub  = 1'b1;
               delta_in = alu_sum;
               state_in = S_SPK_HI;
            end
         end

         // Step above the limit?
         S_SPK_HI: begin
            alu_a   = spike_x;
            alu_b   = delta_ff;
            alu_sub = 1'b1;
            if (alu_flags.neg) begin
               lo_sel_in = 1'b0;
               state_in  = S_SPK_FIX;
            end else begin
               state_in  = S_SPK_LO;
            end
         end

         // Step below minus the limit?
         S_SPK_LO: begin
            alu_a = delta_ff;
            alu_b = spike_x;
            if (alu_flags.neg) begin
               lo_sel_in = 1'b1;
               state_in  = S_SPK_FIX;
            end else begin
               state_in  = S_ALPHA;
            end
         end

         // Clamp to last output plus or minus the limit
         S_SPK_FIX: begin
            alu_a    = last_x;
            alu_b    = spike_x;
            alu_sub  = lo_sel_ff;
            med_in   = alu_sum[SAMPLE_W-1:0];
            state_in = S_ALPHA;
         end

         // Pick the smoothing weight
         S_ALPHA: begin
            if (!seen_ff) begin
               res_in   = med_ff;
               state_in = S_DONE;
            end else if (tau_ff != '0) begin
               alu_a    = ALU_W'(tau_ff);
               alu_b    = ALU_W'(dt_ff);
               den_in   = alu_sum[DEN_W-1:0];
               state_in = S_DIV_NUM;
            end else if (alpha_man_ff != '0) begin
               alpha_in = ALPHA_W'({alpha_man_ff, {F{1'b0}}} >> 16);
               state_in = S_EMA_DIFF;
            end else begin
               res_in   = med_ff;
               state_in = S_DONE;
            end
         end

         // Dividend dt*2^F + den/2; upper part seeds the remainder
         S_DIV_NUM: begin
            alu_a    = ALU_W'({dt_ff, {F{1'b0}}});
            alu_b    = ALU_W'(den_ff[DEN_W-1:1]);
            rem_in   = DEN_W'(alu_sum[NUM_W-1:F+1]);
            low_in   = alu_sum[F:0];
            cnt_in   = '0;
            state_in = S_DIV_STEP;
         end

         // Restoring division, one quotient bit per cycle
         S_DIV_STEP: begin
            alu_a    = ALU_W'(div_trial);
            alu_b    = ALU_W'(den_ff);
            alu_sub  = 1'b1;
            rem_in   = alu_flags.neg ? div_trial[DEN_W-1:0] : alu_sum[DEN_W-1:0];
            alpha_in = {alpha_ff[F-1:0], !alu_flags.neg};
            low_in   = {low_ff[F-1:0], 1'b0};
            cnt_in   = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(F)) begin
               state_in = S_DIV_CLAMP;
            end
         end

         S_DIV_CLAMP: begin
            if (alpha_ff < ALPHA_MIN) begin
               alpha_in = ALPHA_MIN;
            end else if (alpha_ff > ALPHA_ONE) begin
               alpha_in = ALPHA_ONE;
            end
            state_in = S_EMA_DIFF;
         end

         // EMA: last + round(alpha * (value - last) / 2^F)
         S_EMA_DIFF: begin
            alu_a    = med_x;
            alu_b    = last_x;
            alu_sub  = 1'b1;
            delta_in = alu_sum;
            state_in = S_EMA_MUL;
         end

         S_EMA_MUL: begin
            prod_in  = PROD_W'(alpha_s) * PROD_W'(diff_s);
            state_in = S_EMA_RND;
         end

         S_EMA_RND: begin
            alu_a    = prod_sh[ALU_W-1:0];
            alu_b    = ALU_W'(1);
            delta_in = alu_sum;
            state_in = S_EMA_ADD;
         end

         S_EMA_ADD: begin
            alu_a    = last_x;
            alu_b    = step_half;
            res_in   = alu_sum[SAMPLE_W-1:0];
            state_in = S_DONE;
         end

         // Hand the result to the output register once it is free
         S_DONE: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_valid_in = 1'b1;
               out_data_in  = res_ff;
               last_in      = res_ff;
               seen_in      = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         last_ff      <= '0;
         seen_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         seen_ff      <= seen_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      dt_ff       <= dt_in;
      med_ff      <= med_in;
      cand_ff     <= cand_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      rank_ff     <= rank_in;
      delta_ff    <= delta_in;
      lo_sel_ff   <= lo_sel_in;
      alpha_ff    <= alpha_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      low_ff      <= low_in;
      cnt_ff      <= cnt_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
      out_data_ff <= out_data_in;
   end

   a_div_rem_bound : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV_STEP |-> rem_ff < den_ff)
      else $error("divider remainder not below divisor");

   a_alpha_bound : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMA_MUL |-> alpha_ff <= ALPHA_ONE)
      else $error("EMA weight above one");

   a_seen_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(seen_ff) |-> $past(state_ff == S_DONE))
      else $error("first-sample flag set outside output load");

   a_last_tracks_out : assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> last_ff == out_data_ff)
      else $error("last output differs from presented result");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the median/spike-clamp/EMA weight filter.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import msef_pkg::*;

   localparam int MAX_WIN           = 9;
   localparam int ALPHA_BITS        = 16;
   localparam longint ALPHA_ONE     = longint'(1) << ALPHA_BITS;
   localparam longint ALPHA_MIN     = (ALPHA_ONE + 9999) / 10000;
   localparam int HOLD_CYCLES       = 600;
   localparam int SETTLE_CYCLES     = 4;
   localparam int TAIL_CYCLES       = 300;
   localparam int MAX_REPORTS       = 30;
   localparam int RANDOM_PHASES     = 9;
   localparam int PHASE_ITEMS       = 50;
   localparam longint RUN_LIMIT_NS  = 4_000_000;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = {CSR_INDEX_W{1'b1}};

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic [ELAPSED_W-1:0]       elapsed_ms;
   } reading_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_write_en;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;

   msef_req_if req_chan ();
   msef_rsp_if rsp_chan ();

   median_spike_ema_filter #(
      .MAX_WINDOW      (MAX_WIN),
      .ALPHA_FRAC_BITS (ALPHA_BITS)
   ) uut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // Filter model: register copies and window state
   logic [INTERVAL_W-1:0]       cfg_interval;
   logic [ALPHA_MAN_W-1:0]      cfg_alpha;
   logic [TAU_W-1:0]            cfg_tau;
   logic [SPIKE_W-1:0]          cfg_spike;
   int unsigned                 win_len;
   logic signed [SAMPLE_W-1:0]  win_store [MAX_WIN];
   int unsigned                 win_fill;
   int unsigned                 win_next;
   logic signed [SAMPLE_W-1:0]  last_weight;
   bit                          have_weight;

   reading_type                 reading_backlog [$];
   logic signed [SAMPLE_W-1:0]  filtered_due [$];
   reading_type                 next_reading;
   logic signed [SAMPLE_W-1:0]  weight_due;

   int send_idle_pct;
   int recv_idle_pct;
   int mismatch_count;
   int hold_requests;
   int holds_served;
   int hold_left;

   // Runs one sample through window, clamp and EMA; updates model state
   function automatic logic signed [SAMPLE_W-1:0] smooth_weight(
      input logic signed [SAMPLE_W-1:0] sample,
      input logic [ELAPSED_W-1:0]       elapsed);
      logic signed [SAMPLE_W-1:0] sorted [MAX_WIN];
      logic signed [SAMPLE_W-1:0] med, key, lim, result;
      longint delta, spike_span, dt, den, alpha, num;
      bit smooth;
      int i, j;
      med = sample;
      if (win_len > 1) begin
         if (win_fill < win_len) begin
            win_store[win_fill] = sample;
            win_fill++;
         end else begin
            if (win_next >= win_len) win_next = 0;
            win_store[win_next] = sample;
            win_next = (win_next + 1) % win_len;
         end
         for (i = 0; i < win_fill; i++) sorted[i] = win_store[i];
         for (i = 1; i < win_fill; i++) begin
            key = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > key) begin
               sorted[j] = sorted[j-1];
               j--;
            end
            sorted[j] = key;
         end
         // even fill picks the upper middle entry
         med = sorted[win_fill / 2];
      end

      // slew clamp against the previous output
      lim = med;
      if (cfg_spike != 0 && have_weight) begin
         spike_span = longint'({1'b0, cfg_spike});
         delta = longint'(med) - longint'(last_weight);
         if (delta > spike_span) lim = SAMPLE_W'(longint'(last_weight) + spike_span);
         if (delta < -spike_span) lim = SAMPLE_W'(longint'(last_weight) - spike_span);
      end

      // weight selection: time constant first, then manual, else pass-through
      alpha = ALPHA_ONE;
      smooth = 1'b0;
      if (cfg_tau != 0) begin
         dt = have_weight ? longint'(elapsed) : longint'(cfg_interval);
         if (dt == 0) dt = longint'(cfg_interval);
         den = longint'(cfg_tau) + dt;
         alpha = ((dt << ALPHA_BITS) + den / 2) / den;
         if (alpha < ALPHA_MIN) alpha = ALPHA_MIN;
         if (alpha > ALPHA_ONE) alpha = ALPHA_ONE;
         smooth = 1'b1;
      end else if (cfg_alpha != 0) begin
         alpha = longint'(cfg_alpha);
         smooth = 1'b1;
      end

      if (have_weight && smooth) begin
         num = alpha * longint'(lim) + (ALPHA_ONE - alpha) * longint'(last_weight);
         result = SAMPLE_W'((num + ALPHA_ONE / 2) >>> ALPHA_BITS);
      end else begin
         result = lim;
      end
      last_weight = result;
      have_weight = 1'b1;
      return result;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $time, what);
   endtask

   // One register write; leaves the write enable up for back-to-back writes
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= data;
      case (idx)
         CSR_SAMPLE_INTERVAL: cfg_interval = data[INTERVAL_W-1:0];
         CSR_ALPHA_MANUAL:    cfg_alpha = data[ALPHA_MAN_W-1:0];
         CSR_TIME_CONSTANT:   cfg_tau = data[TAU_W-1:0];
         CSR_MEDIAN_WINDOW: begin
            // length forced odd and into 1..MAX_WIN; window emptied
            win_len = 32'(data[WINLEN_W-1:0]);
            if (win_len < 1) win_len = 1;
            if (win_len > MAX_WIN) win_len = MAX_WIN;
            if (win_len % 2 == 0) win_len++;
            if (win_len > MAX_WIN) win_len -= 2;
            win_fill = 0;
            win_next = 0;
         end
         CSR_SPIKE_LIMIT:     cfg_spike = data[SPIKE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] interval,
                            input logic [CSR_DATA_W-1:0] alpha,
                            input logic [CSR_DATA_W-1:0] tau,
                            input logic [CSR_DATA_W-1:0] window,
                            input logic [CSR_DATA_W-1:0] spike);
      write_reg(CSR_SAMPLE_INTERVAL, interval);
      write_reg(CSR_ALPHA_MANUAL, alpha);
      write_reg(CSR_TIME_CONSTANT, tau);
      write_reg(CSR_MEDIAN_WINDOW, window);
      write_reg(CSR_SPIKE_LIMIT, spike);
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure_random();
      logic [CSR_DATA_W-1:0] interval, alpha, tau, spike;
      case ($urandom_range(4))
         0: interval = 10;
         1: interval = 65535;
         2: interval = $urandom_range(10, 500);
         3: interval = CSR_DATA_W'($urandom());
         default: interval = 0;
      endcase
      case ($urandom_range(3))
         0: alpha = 0;
         1: alpha = 65535;
         2: alpha = 1;
         default: alpha = CSR_DATA_W'($urandom());
      endcase
      case ($urandom_range(4))
         0, 1: tau = 0;
         2: tau = 1000000;
         3: tau = $urandom_range(1, 2000);
         default: tau = CSR_DATA_W'($urandom());
      endcase
      case ($urandom_range(4))
         0: spike = 0;
         1: spike = 31'h7FFF_FFFF;
         2: spike = $urandom_range(1, 64);
         3: spike = $urandom_range(1, 4096);
         default: spike = CSR_DATA_W'($urandom());
      endcase
      if ($urandom_range(3) == 0) write_reg(CSR_UNMAPPED, CSR_DATA_W'($urandom()));
      configure(interval, alpha, tau, CSR_DATA_W'($urandom()), spike);
   endtask

   task automatic queue_reading(input logic signed [SAMPLE_W-1:0] sample,
                                input logic [ELAPSED_W-1:0] elapsed);
      reading_backlog.push_back('{sample, elapsed});
   endtask

   // Mostly a noisy steady load, with spikes, odd gaps and raw noise mixed in
   task automatic queue_random_readings(input int count);
      logic signed [SAMPLE_W-1:0] level, value;
      logic [ELAPSED_W-1:0] gap;
      int k;
      level = $signed($urandom()) >>> $urandom_range(4, 31);
      for (k = 0; k < count; k++) begin
         level = level + $urandom_range(0, 64) - 32;
         value = level + $urandom_range(0, 255) - 128;
         gap = $urandom_range(20, 300);
         case ($urandom_range(9))
            0: value = level + ($signed($urandom()) >>> $urandom_range(8, 20));
            1: gap = $urandom_range(1) ? '0 : '1;
            2: begin
               value = $urandom();
               gap = ELAPSED_W'($urandom());
            end
            default: ;
         endcase
         queue_reading(value, gap);
      end
   endtask

   // Idle point: nothing queued, nothing offered, nothing outstanding
   task automatic wait_drained();
      do @(negedge clock);
      while (reading_backlog.size() != 0 || req_chan.valid || filtered_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Sample driver: one transfer per accepted reading, random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid      <= 1'b0;
         req_chan.sample     <= '0;
         req_chan.elapsed_ms <= '0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            filtered_due.push_back(smooth_weight(req_chan.sample, req_chan.elapsed_ms));
         if (!req_chan.valid || req_chan.ready) begin
            if (reading_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_reading = reading_backlog.pop_front();
               req_chan.valid      <= 1'b1;
               req_chan.sample     <= next_reading.sample;
               req_chan.elapsed_ms <= next_reading.elapsed_ms;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, started on request
   always @(posedge clock) begin
      if (reset) begin
         hold_left    <= 0;
         holds_served <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         hold_left    <= HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (filtered_due.size() == 0) begin
               report_mismatch($sformatf("filtered_weight %0d with nothing outstanding",
                                         rsp_chan.filtered_weight));
            end else begin
               weight_due = filtered_due.pop_front();
               if (rsp_chan.filtered_weight !== weight_due)
                  report_mismatch($sformatf("filtered_weight %0d, model %0d",
                                            rsp_chan.filtered_weight, weight_due));
            end
         end
         rsp_chan.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("testbench failed");
      $finish;
   end

   // Stimulus sequence
   initial begin
      reset               <= 1'b1;
      csr_write_en        <= 1'b0;
      csr_index           <= CSR_SAMPLE_INTERVAL;
      csr_data            <= '0;
      cfg_interval  = INTERVAL_RESET;
      cfg_alpha     = ALPHA_MAN_RESET;
      cfg_tau       = TAU_RESET;
      cfg_spike     = SPIKE_RESET;
      win_len       = WINLEN_RESET;
      win_fill      = 0;
      win_next      = 0;
      last_weight   = '0;
      have_weight   = 1'b0;
      mismatch_count = 0;
      hold_requests = 0;
      send_idle_pct = 16;
      recv_idle_pct = 68;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset defaults: first sample loads directly, then manual EMA
      queue_reading(32'sh7FFF_FFFF, 16'd0);
      queue_reading(32'sh8000_0000, 16'hFFFF);
      queue_reading(32'sd0, 16'd1);
      queue_reading(-32'sd1, 16'd120);
      queue_reading(32'sh5555_5555, 16'hAAAA);
      queue_reading(32'shAAAA_AAAA, 16'h5555);
      wait_drained();

      // Even length rounds up to 9; partial fills and ring wrap, slew clamp
      configure(10, 0, 0, 8, 1000);
      queue_reading(1000, 100);
      queue_reading(5000, 100);
      queue_reading(-3000, 100);
      queue_reading(4000, 100);
      queue_reading(-9000, 100);
      repeat (5) queue_reading(20000, 100);
      wait_drained();

      // Zero interval with zero elapsed time gives the minimum weight
      write_reg(CSR_UNMAPPED, '1);
      configure(0, 65535, 1000000, 2, 31'h7FFF_FFFF);
      queue_reading(32'sh7FFF_FFFF, 16'd0);
      queue_reading(32'sh8000_0000, 16'hFFFF);
      queue_reading(12345, 16'd0);
      queue_reading(-12345, 16'hFFFF);
      queue_reading(0, 16'd1);
      wait_drained();

      // Tiny time constant, oversize window length, tightest clamp
      configure(65535, 1, 1, 15, 1);
      queue_reading(1000, 16'hFFFF);
      queue_reading(-1000, 16'd1);
      wait_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         send_idle_pct = (phase < 3) ? 16 : (phase < 6) ? 68 : 0;
         recv_idle_pct = (phase < 3) ? 68 : (phase < 6) ? 16 : 0;
         configure_random();
         if (phase == 7) hold_requests++;
         queue_random_readings(PHASE_ITEMS);
         // sender pauses until every outstanding result is in
         if (phase == 1) wait_drained();
         queue_random_readings(PHASE_ITEMS);
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/msef_pkg.sv
rtl/msef_if.sv
rtl/msef_alu.sv
rtl/msef_window.sv
rtl/median_spike_ema_filter.sv
tb/testbench.sv
